### hw/rtl/avrd_pkg.sv
// ----------------------------------------------------------------------------
// avrd_pkg
// shared constants, codes and control structs of the animation value run
// decoder
// ----------------------------------------------------------------------------
package avrd_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    // walk position must hold a step of up to 256 words past the last entry
    localparam int POS_W       = $clog2(TABLE_DEPTH + 512);

    // field widths
    localparam int IDX_W      = 10;
    localparam int WORD_W     = 16;
    localparam int FRAME_W    = 16;
    localparam int VALUE_W    = 40;
    localparam int STATUS_W   = 2;
    localparam int SCALE_W    = 24;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    // word modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_FOUND  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENDED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PAST   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT = 2'd1;

    // controller to datapath commands
    typedef struct packed {
        logic write;     // store a table word
        logic start;     // begin a query walk, read word 0
        logic step;      // skip the current run, read next header
        logic absent;    // result: channel absent
        logic ended;     // result: run list ended
        logic past;      // result: walked past store
        logic sample;    // result: scaled sample
        logic load_out;  // move result into output register
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic present;   // channel present
        logic ended;     // current header ends the list
        logic hit;       // frame lies inside current run
        logic walk_past; // next read would leave the store
    } stat_t;

endpackage

### hw/rtl/avrd_req_if.sv
// ----------------------------------------------------------------------------
// avrd_req_if
// request channel: table writes and frame queries
// ----------------------------------------------------------------------------
interface avrd_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [avrd_pkg::IDX_W-1:0]   word_index;
    logic [avrd_pkg::WORD_W-1:0]  word_value;
    logic [avrd_pkg::FRAME_W-1:0] frame_number;

    modport source (output valid, mode, word_index, word_value, frame_number,
                    input ready);
    modport sink   (input valid, mode, word_index, word_value, frame_number,
                    output ready);
endinterface

### hw/rtl/avrd_rsp_if.sv
// ----------------------------------------------------------------------------
// avrd_rsp_if
// response channel: scaled sample and status
// ----------------------------------------------------------------------------
interface avrd_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [avrd_pkg::VALUE_W-1:0]  scaled_value;
    logic [avrd_pkg::STATUS_W-1:0]        status;

    modport source (output valid, scaled_value, status, input ready);
    modport sink   (input valid, scaled_value, status, output ready);
endinterface

### hw/rtl/avrd_cfg_if.sv
// ----------------------------------------------------------------------------
// avrd_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface avrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [avrd_pkg::CFG_IDX_W-1:0]  index;
    logic [avrd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/avrd_ram.sv
// ----------------------------------------------------------------------------
// avrd_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module avrd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/avrd_dpath.sv
// ----------------------------------------------------------------------------
// avrd_dpath
// datapath: channel table, run walk registers, scaling multiply, output
// register and configuration registers
// ----------------------------------------------------------------------------
module avrd_dpath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [avrd_pkg::IDX_W-1:0]            word_index,
    input  logic [avrd_pkg::WORD_W-1:0]           word_value,
    input  logic [avrd_pkg::FRAME_W-1:0]          frame_number,
    input  logic                                  cfg_valid,
    input  logic [avrd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [avrd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  avrd_pkg::cmd_t                        cmd,
    output avrd_pkg::stat_t                       stat,
    output logic signed [avrd_pkg::VALUE_W-1:0]   scaled_value,
    output logic [avrd_pkg::STATUS_W-1:0]         status
);

    // configuration
    logic [avrd_pkg::SCALE_W-1:0] scale_reg;
    logic                         present_reg;

    // walk state
    logic [avrd_pkg::FRAME_W-1:0] k_reg;
    logic [avrd_pkg::POS_W-1:0]   pos_reg;
    logic                         first_reg;

    // pending and delivered result
    logic signed [avrd_pkg::VALUE_W-1:0] res_value_reg;
    logic [avrd_pkg::STATUS_W-1:0]       res_status_reg;
    logic signed [avrd_pkg::VALUE_W-1:0] out_value_reg;
    logic [avrd_pkg::STATUS_W-1:0]       out_status_reg;

    // table port
    logic                         ram_we;
    logic [avrd_pkg::ADDR_W-1:0]  ram_raddr;
    logic [avrd_pkg::WORD_W-1:0]  ram_rdata;

    // header decode
    logic [avrd_pkg::BYTE_W-1:0]  total;
    logic [avrd_pkg::BYTE_W-1:0]  count;
    logic                         hit;
    logic [avrd_pkg::POS_W-1:0]   pos_step;
    logic [avrd_pkg::POS_W-1:0]   sidx;
    logic [avrd_pkg::POS_W-1:0]   next_addr;
    logic signed [avrd_pkg::VALUE_W-1:0] product;

    assign ram_we = cmd.write && (32'(word_index) < avrd_pkg::TABLE_DEPTH);

    avrd_ram #(
        .WIDTH (avrd_pkg::WORD_W),
        .DEPTH (avrd_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (avrd_pkg::ADDR_W'(word_index)),
        .wdata (word_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign total = ram_rdata[avrd_pkg::WORD_W-1:avrd_pkg::BYTE_W];
    assign count = ram_rdata[avrd_pkg::BYTE_W-1:0];
    assign hit   = avrd_pkg::FRAME_W'(total) > k_reg;

    assign pos_step = pos_reg + avrd_pkg::POS_W'(count) + avrd_pkg::POS_W'(1);

    // offset inside run, or last stored value when the offset passes them
    always_comb
    begin
        if (avrd_pkg::FRAME_W'(count) > k_reg)
        begin
            sidx = pos_reg + avrd_pkg::POS_W'(k_reg[avrd_pkg::BYTE_W-1:0])
                   + avrd_pkg::POS_W'(1);
        end
        else
        begin
            sidx = pos_reg + avrd_pkg::POS_W'(count);
        end
    end

    assign next_addr = hit ? sidx : pos_step;
    assign ram_raddr = cmd.start ? '0 : next_addr[avrd_pkg::ADDR_W-1:0];

    assign stat.present   = present_reg;
    assign stat.ended     = !first_reg && (total == '0);
    assign stat.hit       = hit;
    assign stat.walk_past = next_addr >= avrd_pkg::POS_W'(avrd_pkg::TABLE_DEPTH);

    // signed 16-bit sample times unsigned 24-bit scale, exact in 40 bits
    assign product = avrd_pkg::VALUE_W'($signed(ram_rdata))
                     * avrd_pkg::VALUE_W'($signed({1'b0, scale_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= avrd_pkg::SCALE_RESET;
            present_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                avrd_pkg::REG_SCALE:   scale_reg   <= cfg_data[avrd_pkg::SCALE_W-1:0];
                avrd_pkg::REG_PRESENT: present_reg <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            k_reg     <= frame_number;
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.step)
        begin
            k_reg     <= k_reg - avrd_pkg::FRAME_W'(total);
            pos_reg   <= pos_step;
            first_reg <= 1'b0;
        end

        if (cmd.sample)
        begin
            res_value_reg  <= product;
            res_status_reg <= avrd_pkg::ST_FOUND;
        end
        else if (cmd.absent)
        begin
            res_value_reg  <= '0;
            res_status_reg <= avrd_pkg::ST_ABSENT;
        end
        else if (cmd.ended)
        begin
            res_value_reg  <= '0;
            res_status_reg <= avrd_pkg::ST_ENDED;
        end
        else if (cmd.past)
        begin
            res_value_reg  <= '0;
            res_status_reg <= avrd_pkg::ST_PAST;
        end

        if (cmd.load_out)
        begin
            out_value_reg  <= res_value_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign scaled_value = out_value_reg;
    assign status       = out_status_reg;

    // a skipped run moves the walk forward and never grows the frame offset
    a_step_forward: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (pos_reg > $past(pos_reg)) && (k_reg <= $past(k_reg)))
        else $error("walk step did not advance");

    // a step is only taken from a run the frame lies beyond
    a_step_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !hit && !stat.walk_past)
        else $error("step issued inside a run or past the store");

endmodule

### hw/rtl/avrd_ctrl.sv
// ----------------------------------------------------------------------------
// avrd_ctrl
// controller: request handshake, run walk sequencing, response valid
// ----------------------------------------------------------------------------
module avrd_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_mode,
    output logic            req_ready,
    input  logic            rsp_ready,
    output logic            rsp_valid,
    output avrd_pkg::cmd_t  cmd,
    input  avrd_pkg::stat_t stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_HDR    = 2'd1;
    localparam logic [1:0] S_SAMPLE = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_mode == avrd_pkg::MODE_QUERY)
                    begin
                        if (!stat.present)
                        begin
                            cmd.absent = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_HDR;
                        end
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            S_HDR:
            begin
                if (stat.ended)
                begin
                    cmd.ended  = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.walk_past)
                begin
                    cmd.past   = 1'b1;
                    state_next = S_FINISH;
                end
                else if (stat.hit)
                begin
                    state_next = S_SAMPLE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_SAMPLE:
            begin
                cmd.sample = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

    // a finished result with a free output slot is shown next cycle
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && slot_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished result not delivered");

    // a query on an absent channel goes straight to delivery
    a_absent_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && req_mode == avrd_pkg::MODE_QUERY
         && !stat.present) |=> state_reg == S_FINISH)
        else $error("absent query not finished");

    // an ending header stops the walk
    a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HDR && stat.ended) |=> state_reg == S_FINISH)
        else $error("walk continued past end of run list");

endmodule

### hw/rtl/anim_value_run_decoder_core.sv
// ----------------------------------------------------------------------------
// anim_value_run_decoder_core
// run-length decoder for one animation channel with scaled output
// ----------------------------------------------------------------------------
// write word: no response, the next word is taken in the following cycle
// query word: reads word 0, steps over one run header at a time, then the
// scaling multiply and the hand over to the output register; a list end or a
// walk past the store skips the multiply, an absent channel goes straight to
// the hand over; one query in flight, next word taken once its response loads
// reset: controller idle, no response pending, scale 1.0, channel present
module anim_value_run_decoder_core (
    input logic        clk,
    input logic        rst_n,
    avrd_req_if.sink   req,
    avrd_rsp_if.source rsp,
    avrd_cfg_if.sink   cfg
);

    // command and status between controller and datapath
    avrd_pkg::cmd_t  cmd;
    avrd_pkg::stat_t stat;

    // configuration writes are always taken, block is idle by contract
    assign cfg.ready = 1'b1;

    // controller: walks the run list one header per cycle, then steps through
    // the scaling multiply and the hand over to the output register; a response
    // still waiting in the output register holds the hand over
    avrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath: table ram, frame offset and position registers, multiplier
    // and the output register that holds a result until it is taken
    // table contents are not cleared by reset and read undefined until written
    avrd_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .word_index   (req.word_index),
        .word_value   (req.word_value),
        .frame_number (req.frame_number),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .cmd          (cmd),
        .stat         (stat),
        .scaled_value (rsp.scaled_value),
        .status       (rsp.status)
    );

endmodule
